[rtl/lru_kv_pkg.sv]
// Shared types and constants of the LRU key-value cache.
`default_nettype none

package lru_kv_pkg;

  // Entry count the cache is built with unless the top level overrides it.
  localparam int DEFAULT_ENTRIES = 16;

  // Request and result field widths.
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // Capacity register: width and value after reset.
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register indexes (byte address 4 * index).
  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } reg_idx_t;

  // Request kinds carried on in_tuser.
  typedef enum logic [0:0] {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

endpackage : lru_kv_pkg

`default_nettype wire

[rtl/lru_key_value_cache.sv]
// Fully associative key-value cache with least-recently-used replacement.
`default_nettype none

// Each request is a get or a put of a 32-bit key. All entries compare the key in
// parallel; a get hit returns the stored value, a put hit overwrites it, and a put miss
// fills the lowest free entry or, once the entry count has reached the capacity
// register (0 acts as 1, values above ENTRIES act as ENTRIES), evicts the least
// recent entry first. Every request produces exactly one result: hit, read_value
// (zero except on a get hit) and evicted. Requests are registered on entry, and the
// key match, recency update and entry write happen when the request register
// advances, together with loading the result register, so the cache takes one
// request per cycle while the result is not back-pressured; a single lookup-and-update
// stage over all entries sits between them. A back-pressured result register stalls the
// request register and then in_tready. Lowering the capacity below the present count
// keeps the entries; each later put miss evicts one and inserts one. Capacity is
// register 0 at byte address 0; write it only while no request is in flight.
module lru_key_value_cache
  import lru_kv_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Request channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [KEY_W+VAL_W-1:0] in_tdata,  // [31:0] key, [63:32] value
  input  wire logic [0:0]            in_tuser,  // [0] cmd (0 get, 1 put)
  // Result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [VAL_W-1:0]           out_tdata,  // [31:0] read_value
  output logic [1:0]                 out_tuser,  // [0] hit, [1] evicted
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int EW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // ---------------------------------------------------------------- configuration
  logic [CAP_W-1:0] cap_r;
  logic             cfg_wr;
  logic             cfg_sel_cap;

  assign pready      = 1'b1;
  assign cfg_sel_cap = (reg_idx_t'(paddr[2]) == REG_CAPACITY);
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign prdata      = cfg_sel_cap ? APB_DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && cfg_sel_cap) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // ---------------------------------------------------------------- request register
  logic             stg_valid_r;
  cmd_t             stg_cmd_r;
  logic [KEY_W-1:0] stg_key_r;
  logic [VAL_W-1:0] stg_value_r;
  logic             out_valid_r;
  logic             advance;

  // Advance the request into the result register when that register is free or drains.
  assign advance   = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_cmd_r   <= cmd_t'(in_tuser[0]);
      stg_key_r   <= in_tdata[KEY_W-1:0];
      stg_value_r <= in_tdata[KEY_W+VAL_W-1:KEY_W];
    end
  end

  // ---------------------------------------------------------------- entry state
  logic [KEY_W-1:0]  key_r   [ENTRIES];
  logic [VAL_W-1:0]  value_r [ENTRIES];
  logic [RANK_W-1:0] rank_r  [ENTRIES];
  logic [RANK_W-1:0] rank_nxt[ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic [ENTRIES-1:0] match, victim_oh, valid_kept, free_oh;
  logic [ENTRIES-1:0] key_we, value_we;
  logic               hit, is_put, evict;
  logic [RANK_W-1:0]  hit_rank, last_rank;
  logic [VAL_W-1:0]   hit_value;
  logic [EW-1:0]      cap_ext, eff_cap;

  // Clamp the capacity into 1..ENTRIES.
  always_comb begin
    cap_ext = EW'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(ENTRIES)) begin
      eff_cap = EW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Ranks of valid entries always form 0..count-1, so the least recent entry is the
  // one whose rank equals count-1.
  assign last_rank = RANK_W'(count_r - CNT_W'(1));
  assign is_put    = (stg_cmd_r == CMD_PUT);

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      match[j]     = valid_r[j] && (key_r[j] == stg_key_r);
      victim_oh[j] = valid_r[j] && (rank_r[j] == last_rank);
      hit_rank     = hit_rank | (match[j] ? rank_r[j] : '0);
      hit_value    = hit_value | (match[j] ? value_r[j] : '0);
    end
    hit   = |match;
    evict = is_put && !hit && (EW'(count_r) >= eff_cap) && (count_r != '0);
    valid_kept = evict ? (valid_r & ~victim_oh) : valid_r;
    // Lowest free entry after the eviction.
    free_oh = ~valid_kept & (valid_kept + ENTRIES'(1));
  end

  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      rank_nxt[j] = rank_r[j];
      key_we[j]   = 1'b0;
      value_we[j] = 1'b0;
      if (hit) begin
        // Touch: entries younger than the hit age by one, the hit becomes newest.
        value_we[j] = is_put && match[j];
        if (match[j]) begin
          rank_nxt[j] = '0;
        end else if (valid_r[j] && (rank_r[j] < hit_rank)) begin
          rank_nxt[j] = rank_r[j] + RANK_W'(1);
        end
      end else if (is_put) begin
        // Insert: every kept entry ages, the filled entry becomes newest.
        key_we[j]   = free_oh[j];
        value_we[j] = free_oh[j];
        if (free_oh[j]) begin
          rank_nxt[j] = '0;
        end else if (valid_kept[j]) begin
          rank_nxt[j] = rank_r[j] + RANK_W'(1);
        end
      end
    end
    valid_nxt = (is_put && !hit) ? (valid_kept | free_oh) : valid_r;
    count_nxt = (is_put && !hit && !evict) ? (count_r + CNT_W'(1)) : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= '0;
      end
    end else if (advance) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
    end
  end

  // Keys and values hold no reset; they are read only behind a valid bit.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (key_we[j]) begin
          key_r[j] <= stg_key_r;
        end
        if (value_we[j]) begin
          value_r[j] <= stg_value_r;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result register
  logic             out_hit_r, out_evicted_r;
  logic [VAL_W-1:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit_r     <= hit;
      out_evicted_r <= evict;
      out_value_r   <= (hit && !is_put) ? hit_value : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_evicted_r, out_hit_r};

  // ---------------------------------------------------------------- checks
  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count disagrees with valid bits");

  a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r |-> $onehot0(match))
    else $error("key matches more than one entry");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evicted_r |-> !out_hit_r)
    else $error("eviction reported on a hit");

  a_put_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_put && !hit |-> $onehot(free_oh))
    else $error("put miss found no free entry");

  a_put_keeps_entry: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_put |=> count_r != '0)
    else $error("cache empty after a put");

endmodule : lru_key_value_cache

`default_nettype wire
